/* rtl/core/mbfr_pkg.sv */
package mbfr_pkg;

  // Byte store depth.
  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int unsigned ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  // Length counter must hold BUFFER_BYTES itself.
  localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);

  // Fixed field widths.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NBITS_W = 6;
  localparam int unsigned POS_W = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned MAX_BITS = 32;
  // Widest window: 7 bits of offset plus 32 bits span five bytes.
  localparam int unsigned MAX_FETCH = 5;
  localparam int unsigned FETCH_W = 3;
  localparam int unsigned ACC_W = MAX_FETCH * BYTE_W;
  localparam int unsigned SHIFT_W = $clog2(ACC_W);

  // End-of-data compare: bit position plus width against 8 * length.
  localparam int unsigned CMP_W = ((LEN_W + 3) > (POS_W + 1)) ? (LEN_W + 3) : (POS_W + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND   = 2'd0,
    KIND_READ_CUR = 2'd1,
    KIND_READ_POS = 2'd2,
    KIND_SET_CUR  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_WIDE = 2'd1,
    STS_END  = 2'd2,
    STS_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_XTR   = 3'b100
  } state_e;

endpackage

/* rtl/core/msb_first_bit_field_reader_top.sv */
// MSB-first bit field reader.
//
// Requests come in on start with kind_i, byte_value_i, num_bits_i and
// bit_position_i; a request is taken on a clock edge where start is high
// and busy is low. Each request gives exactly one result on value_o and
// status_o, marked by done_o for a single cycle; the receiver cannot stall.
//
// Appends, cursor sets, refused reads and zero-width reads need no fetch:
// the result shows in the cycle after the request and busy stays low,
// so such requests may follow back to back.
// A read of N bits at bit offset k fetches B = ceil((k%8 + N)/8) bytes,
// one per cycle from the single-port byte store (B is 1..5). busy is high
// through the fetch and extract states, and the result is registered after
// extraction; the byte store read port sets the pace of the fetch.
//
// Bit 0 of the stream is bit 7 of the first stored byte. A width above 32
// gives status 1, a field past the loaded length gives status 2, an append
// to a full store gives status 3; value is zero in all those cases and the
// cursor does not move. Reset clears the length and cursor; the store
// contents are not cleared (only loaded bytes are ever read).
module msb_first_bit_field_reader_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mbfr_pkg::KIND_W-1:0]    kind_i,
  input  logic [mbfr_pkg::BYTE_W-1:0]    byte_value_i,
  input  logic [mbfr_pkg::NBITS_W-1:0]   num_bits_i,
  input  logic [mbfr_pkg::POS_W-1:0]     bit_position_i,
  output logic                           done_o,
  output logic [mbfr_pkg::VALUE_W-1:0]   value_o,
  output logic [mbfr_pkg::STATUS_W-1:0]  status_o
);

  // Byte store, written on append, read one byte per cycle while fetching.
  logic [mbfr_pkg::BYTE_W-1:0] mem [mbfr_pkg::BUFFER_BYTES];

  mbfr_pkg::state_e state_q, state_d;
  logic [mbfr_pkg::LEN_W-1:0]   len_q, len_d;
  logic [mbfr_pkg::POS_W-1:0]   cursor_q, cursor_d;

  // Fetch sequencer.
  logic [mbfr_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [mbfr_pkg::FETCH_W-1:0] nbytes_q, nbytes_d;
  logic [mbfr_pkg::FETCH_W-1:0] issued_q, issued_d;
  logic                         pend_q, pend_d;
  logic [mbfr_pkg::BYTE_W-1:0]  rd_q;
  logic [mbfr_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [2:0]                   off_q, off_d;
  logic [mbfr_pkg::NBITS_W-1:0] width_q, width_d;

  // Result register.
  logic                           done_q, done_d;
  logic [mbfr_pkg::VALUE_W-1:0]   value_q, value_d;
  logic [mbfr_pkg::STATUS_W-1:0]  status_q, status_d;

  logic                           accept;
  logic                           rd_en;
  logic                           wr_en;
  mbfr_pkg::kind_e                kind;
  logic [mbfr_pkg::POS_W-1:0]     rd_start;
  logic [mbfr_pkg::CMP_W-1:0]     rd_end;
  logic [mbfr_pkg::CMP_W-1:0]     len_bits;
  logic                           too_wide;
  logic                           past_end;
  logic [mbfr_pkg::NBITS_W:0]     span_bits;
  logic [mbfr_pkg::SHIFT_W-1:0]   shamt;
  logic [mbfr_pkg::ACC_W-1:0]     field_mask;
  logic [mbfr_pkg::ACC_W-1:0]     field;

  assign accept = start && (state_q == mbfr_pkg::ST_IDLE);
  assign busy   = (state_q != mbfr_pkg::ST_IDLE);
  assign kind   = mbfr_pkg::kind_e'(kind_i);

  // Read window checks, evaluated on the request cycle.
  assign rd_start = (kind == mbfr_pkg::KIND_READ_CUR) ? cursor_q : bit_position_i;
  assign rd_end   = mbfr_pkg::CMP_W'(rd_start) + mbfr_pkg::CMP_W'(num_bits_i);
  assign len_bits = mbfr_pkg::CMP_W'(len_q) << 3;
  assign too_wide = (num_bits_i > mbfr_pkg::NBITS_W'(mbfr_pkg::MAX_BITS));
  assign past_end = (rd_end > len_bits);
  // Bits from the first fetched byte's MSB to the field's last bit.
  assign span_bits = (mbfr_pkg::NBITS_W + 1)'(rd_start[2:0]) +
                     (mbfr_pkg::NBITS_W + 1)'(num_bits_i);

  assign wr_en = accept && (kind == mbfr_pkg::KIND_APPEND) &&
                 (len_q < mbfr_pkg::LEN_W'(mbfr_pkg::BUFFER_BYTES));

  // Extraction: drop the trailing bits below the field, then mask to width.
  assign shamt = mbfr_pkg::SHIFT_W'({nbytes_q, 3'b000}) -
                 mbfr_pkg::SHIFT_W'(off_q) - mbfr_pkg::SHIFT_W'(width_q);
  assign field_mask = (mbfr_pkg::ACC_W'(1) << width_q) - mbfr_pkg::ACC_W'(1);
  assign field = (acc_q >> shamt) & field_mask;

  assign rd_en = (state_q == mbfr_pkg::ST_FETCH) && (issued_q != nbytes_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[mbfr_pkg::ADDR_W-1:0]] <= byte_value_i;
    end
    if (rd_en) begin
      rd_q <= mem[addr_q];
    end
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cursor_d = cursor_q;
    addr_d   = addr_q;
    nbytes_d = nbytes_q;
    issued_d = issued_q;
    pend_d   = 1'b0;
    acc_d    = acc_q;
    off_d    = off_q;
    width_d  = width_q;
    done_d   = 1'b0;
    value_d  = value_q;
    status_d = status_q;

    unique case (state_q)
      mbfr_pkg::ST_IDLE: begin
        if (accept) begin
          value_d  = '0;
          status_d = mbfr_pkg::STS_OK;
          unique case (kind)
            mbfr_pkg::KIND_APPEND: begin
              done_d = 1'b1;
              if (wr_en) begin
                len_d = len_q + mbfr_pkg::LEN_W'(1);
              end else begin
                status_d = mbfr_pkg::STS_FULL;
              end
            end
            mbfr_pkg::KIND_SET_CUR: begin
              done_d   = 1'b1;
              cursor_d = bit_position_i;
            end
            mbfr_pkg::KIND_READ_CUR, mbfr_pkg::KIND_READ_POS: begin
              if (too_wide) begin
                done_d   = 1'b1;
                status_d = mbfr_pkg::STS_WIDE;
              end else if (past_end) begin
                done_d   = 1'b1;
                status_d = mbfr_pkg::STS_END;
              end else begin
                if (kind == mbfr_pkg::KIND_READ_CUR) begin
                  cursor_d = cursor_q + mbfr_pkg::POS_W'(num_bits_i);
                end
                if (num_bits_i == '0) begin
                  done_d = 1'b1;
                end else begin
                  state_d  = mbfr_pkg::ST_FETCH;
                  addr_d   = mbfr_pkg::ADDR_W'(rd_start >> 3);
                  nbytes_d = mbfr_pkg::FETCH_W'((span_bits + 7'd7) >> 3);
                  issued_d = '0;
                  off_d    = rd_start[2:0];
                  width_d  = num_bits_i;
                end
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      mbfr_pkg::ST_FETCH: begin
        // One byte read issued per cycle; the data lands in rd_q in the next cycle.
        if (rd_en) begin
          addr_d   = addr_q + mbfr_pkg::ADDR_W'(1);
          issued_d = issued_q + mbfr_pkg::FETCH_W'(1);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          acc_d = {acc_q[mbfr_pkg::ACC_W-mbfr_pkg::BYTE_W-1:0], rd_q};
        end
        if (!rd_en && !pend_q) begin
          state_d = mbfr_pkg::ST_XTR;
        end
      end
      mbfr_pkg::ST_XTR: begin
        done_d   = 1'b1;
        value_d  = field[mbfr_pkg::VALUE_W-1:0];
        status_d = mbfr_pkg::STS_OK;
        state_d  = mbfr_pkg::ST_IDLE;
      end
      default: begin
        state_d = mbfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mbfr_pkg::ST_IDLE;
      len_q    <= '0;
      cursor_q <= '0;
      issued_q <= '0;
      nbytes_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      cursor_q <= cursor_d;
      issued_q <= issued_d;
      nbytes_q <= nbytes_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    acc_q    <= acc_d;
    off_q    <= off_d;
    width_q  <= width_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign done_o   = done_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule
